// ----- rtl/core/b64d_pkg.sv -----
// b64d_pkg: types, constants and the character classifier of the base64 stream decoder.
// Depends on nothing; used by b64d_front, b64d_queue, b64d_back and the top level.
`default_nettype none

package b64d_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;

    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] PLUS_VAL   = 6'd62;
    localparam logic [5:0] SLASH_VAL  = 6'd63;

    typedef enum logic [1:0] {
        CLS_SEXTET = 2'd0,
        CLS_PAD    = 2'd1,
        CLS_BAD    = 2'd2
    } t_cls_kind;

    typedef struct packed {
        t_cls_kind  kind;
        logic [5:0] value;
    } t_cls;

    // one entry per input transaction that yields results
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  last_idx;
        logic        bytes_valid;
        logic        bad;
        logic        eom;
    } t_job;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.kind  = CLS_BAD;
        r.value = 6'd0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r.kind  = CLS_SEXTET;
            r.value = 6'(c - CHAR_UP_A);
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            r.kind  = CLS_SEXTET;
            r.value = 6'(c - CHAR_LO_A + LOWER_BASE);
        end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
            r.kind  = CLS_SEXTET;
            r.value = 6'(c - CHAR_DIG_0 + DIGIT_BASE);
        end else if (c == CHAR_PLUS) begin
            r.kind  = CLS_SEXTET;
            r.value = PLUS_VAL;
        end else if (c == CHAR_SLASH) begin
            r.kind  = CLS_SEXTET;
            r.value = SLASH_VAL;
        end else if (c == CHAR_PAD) begin
            r.kind  = CLS_PAD;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/b64d_char_if.sv -----
// b64d_char_if: input channel of the base64 stream decoder, one character per transaction.
// Depends on nothing.
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/b64d_result_if.sv -----
// b64d_result_if: result channel of the base64 stream decoder, one result per transaction.
// Depends on nothing.
`default_nettype none

interface b64d_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_char;
    logic       last_of_run;
    logic       end_of_message;

    modport source (output valid, output out_byte, output byte_valid, output bad_char,
                    output last_of_run, output end_of_message, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input bad_char,
                    input last_of_run, input end_of_message, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/b64d_front.sv -----
// b64d_front: accepts characters, keeps the group state and builds one job per result run.
// Depends on b64d_pkg and b64d_char_if.
`default_nettype none

module b64d_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    b64d_char_if.sink          i_char,
    input  wire logic          i_q_full,
    output      logic          o_push,
    output      b64d_pkg::t_job o_job
);

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_gp, n_gp;
    logic        r_pad, n_pad;
    logic [1:0]  r_cbp, n_cbp;
    logic        r_discard, n_discard;

    b64d_pkg::t_cls w_cls;
    logic           w_accept;

    assign i_char.ready = !i_q_full;
    assign w_accept     = i_char.valid && !i_q_full;
    assign w_cls        = b64d_pkg::classify(i_char.char_code);

    always_comb begin
        logic [1:0]  emit_cnt;
        logic [17:0] emit_acc;
        logic        full3;
        logic        bad;
        logic        has;
        n_acc     = r_acc;
        n_gp      = r_gp;
        n_pad     = r_pad;
        n_cbp     = r_cbp;
        n_discard = r_discard;
        emit_cnt  = 2'd0;
        emit_acc  = r_acc;
        full3     = 1'b0;
        bad       = 1'b0;
        has       = 1'b0;
        o_job     = '0;

        if (!r_discard) begin
            if (r_pad) begin
                n_gp = r_gp + 2'd1;
                if (r_gp == 2'd3) begin
                    emit_cnt = r_cbp;
                    n_acc = '0; n_gp = '0; n_pad = 1'b0; n_cbp = '0;
                end
            end else begin
                unique case (w_cls.kind)
                    b64d_pkg::CLS_PAD: begin
                        n_pad = 1'b1;
                        n_cbp = r_gp;
                        n_gp  = r_gp + 2'd1;
                        if (r_gp == 2'd3) begin
                            emit_cnt = 2'd3;
                            n_acc = '0; n_gp = '0; n_pad = 1'b0; n_cbp = '0;
                        end
                    end
                    b64d_pkg::CLS_BAD: begin
                        bad       = 1'b1;
                        n_discard = 1'b1;
                        n_acc = '0; n_gp = '0; n_pad = 1'b0; n_cbp = '0;
                    end
                    default: begin
                        if (r_gp == 2'd3) begin
                            full3 = 1'b1;
                            n_acc = '0; n_gp = '0; n_pad = 1'b0; n_cbp = '0;
                        end else begin
                            n_acc = {r_acc[11:0], w_cls.value};
                            n_gp  = r_gp + 2'd1;
                        end
                    end
                endcase
            end
        end

        if (i_char.last_char) begin
            // treat a cut-short final group as padded
            if (!n_discard && (n_gp != 2'd0 || n_pad)) begin
                emit_cnt = n_pad ? n_cbp : n_gp;
                emit_acc = n_acc;
            end
            n_acc = '0; n_gp = '0; n_pad = 1'b0; n_cbp = '0;
            n_discard = 1'b0;
        end

        if (full3) begin
            o_job.word        = {r_acc, w_cls.value};
            o_job.last_idx    = 2'd2;
            o_job.bytes_valid = 1'b1;
            has               = 1'b1;
        end else if (emit_cnt == 2'd3) begin
            o_job.word        = {emit_acc, 6'd0};
            o_job.last_idx    = 2'd1;
            o_job.bytes_valid = 1'b1;
            has               = 1'b1;
        end else if (emit_cnt == 2'd2) begin
            o_job.word        = {emit_acc[11:0], 12'd0};
            o_job.last_idx    = 2'd0;
            o_job.bytes_valid = 1'b1;
            has               = 1'b1;
        end else if (bad || i_char.last_char) begin
            o_job.bad = bad;
            has       = 1'b1;
        end
        o_job.eom = i_char.last_char;
        o_push    = w_accept && has;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_gp      <= '0;
            r_pad     <= 1'b0;
            r_cbp     <= '0;
            r_discard <= 1'b0;
        end else if (w_accept) begin
            r_acc     <= n_acc;
            r_gp      <= n_gp;
            r_pad     <= n_pad;
            r_cbp     <= n_cbp;
            r_discard <= n_discard;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_queue.sv -----
// b64d_queue: short register queue of jobs between the front and the back.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue #(
    parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire b64d_pkg::t_job i_job,
    input  wire logic           i_pop,
    output      b64d_pkg::t_job o_job,
    output      logic           o_full,
    output      logic           o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_back.sv -----
// b64d_back: takes jobs from the queue and hands out their results one per transaction.
// Depends on b64d_pkg and b64d_result_if.
`default_nettype none

module b64d_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire b64d_pkg::t_job i_job,
    input  wire logic           i_q_empty,
    output      logic           o_pop,
    b64d_result_if.source       o_result
);

    logic           r_busy;
    b64d_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           w_done;
    logic           w_last;

    assign w_last = (r_idx == r_job.last_idx);
    assign w_done = r_busy && o_result.ready && w_last;
    assign o_pop  = !i_q_empty && (!r_busy || w_done);

    assign o_result.valid          = r_busy;
    assign o_result.byte_valid     = r_job.bytes_valid;
    assign o_result.bad_char       = r_job.bad;
    assign o_result.last_of_run    = w_last;
    assign o_result.end_of_message = r_job.eom && w_last;

    always_comb begin
        case (r_idx)
            2'd0:    o_result.out_byte = r_job.word[23:16];
            2'd1:    o_result.out_byte = r_job.word[15:8];
            2'd2:    o_result.out_byte = r_job.word[7:0];
            default: o_result.out_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy && o_result.ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/base64_stream_decoder.sv -----
// Channel   Dir  Interface        Transaction
// i_char    in   b64d_char_if     one base64 character with its end-of-message mark
// o_result  out  b64d_result_if   one decoded byte, error or end marker
//
// One character is taken per cycle while the job queue has room.
// A character that closes a group holds the result port for up to three results;
// the job queue (QUEUE_DEPTH entries) absorbs that while characters keep coming.
// Jobs are registered in the queue and then in the back. Reset: synchronous.
// A stalled result port backs up through the queue to i_char.ready.
// base64_stream_decoder: top level; joins the front, the job queue and the back.
// Depends on b64d_pkg, b64d_char_if, b64d_result_if, b64d_front, b64d_queue, b64d_back.
`default_nettype none

module base64_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    b64d_char_if.sink     i_char,
    b64d_result_if.source o_result
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    b64d_pkg::t_job w_in_job;
    b64d_pkg::t_job w_out_job;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_q_full(w_full),
        .o_push  (w_push),
        .o_job   (w_in_job)
    );

    b64d_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_in_job),
        .i_pop  (w_pop),
        .o_job  (w_out_job),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_out_job),
        .i_q_empty(w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

`ifndef SYNTH
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.bad_char |-> !o_result.byte_valid && o_result.last_of_run)
        else $error("error result shares a run with bytes");

    a_eom_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.end_of_message |-> o_result.last_of_run)
        else $error("end of message before end of run");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job queue read while empty");

    a_push_only_on_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full && i_char.valid)
        else $error("job pushed without an accepted character");
`endif

endmodule

`default_nettype wire
